FILE: hdl/b64c_pkg.sv
// Shared types, constants and alphabet functions for the base64 stream codec.
// No dependencies; used by b64c_step and base64_stream_codec.
package b64c_pkg;

  localparam logic [7:0] PadChar   = 8'h3D;  // '='
  localparam logic [7:0] BadSextet = 8'hFF;
  localparam logic       DirEncode = 1'b0;
  localparam logic       DirDecode = 1'b1;

  typedef struct packed {
    logic [1:0]  pos;
    logic [23:0] buffer;
    logic        pad_seen;
    logic        bad;
  } group_t;

  typedef struct packed {
    logic [2:0]      count;   // results produced, 0..4
    logic [3:0][7:0] bytes;   // result i in bytes[i]
    logic            bad;
  } burst_t;

  function automatic logic [7:0] enc_char(input logic [5:0] s);
    logic [7:0] c;
    if (s < 6'd26)      c = 8'h41 + {2'b00, s};
    else if (s < 6'd52) c = 8'h61 + {2'b00, s} - 8'd26;
    else if (s < 6'd62) c = 8'h30 + {2'b00, s} - 8'd52;
    else if (s == 6'd62) c = 8'h2B;
    else                c = 8'h2F;
    return c;
  endfunction

  // Returns the sextet value, or BadSextet for characters outside the alphabet.
  function automatic logic [7:0] dec_sextet(input logic [7:0] c);
    logic [7:0] v;
    if (c >= 8'h41 && c <= 8'h5A)      v = c - 8'h41;
    else if (c >= 8'h61 && c <= 8'h7A) v = c - 8'h61 + 8'd26;
    else if (c >= 8'h30 && c <= 8'h39) v = c - 8'h30 + 8'd52;
    else if (c == 8'h2B)               v = 8'd62;
    else if (c == 8'h2F)               v = 8'd63;
    else                               v = BadSextet;
    return v;
  endfunction

endpackage

FILE: hdl/b64c_step.sv
// Combinational step of the codec: next group state and the burst of results
// for one accepted item. Depends on b64c_pkg.
module b64c_step (
  input  logic            dir_i,
  input  b64c_pkg::group_t grp_i,
  input  logic [7:0]      byte_i,
  input  logic            last_i,
  output b64c_pkg::group_t grp_o,
  output b64c_pkg::burst_t burst_o
);
  import b64c_pkg::*;

  logic [1:0]  pos;
  logic [2:0]  pos1;
  logic [23:0] buf_e;
  logic [23:0] buf_d;
  logic [7:0]  v;
  logic [2:0]  emit;
  logic        vbad;
  logic [5:0]  s0, s1, s2;
  logic [7:0]  d3;
  logic [23:0] dbuf;

  always_comb begin
    grp_o   = grp_i;
    burst_o = '0;
    pos     = grp_i.pos;
    pos1    = 3'd0;
    buf_e   = grp_i.buffer;
    buf_d   = grp_i.buffer;
    v       = dec_sextet(byte_i);
    vbad    = (v == BadSextet);
    emit    = 3'd0;
    dbuf    = grp_i.buffer;
    d3      = 8'd0;

    if (dir_i == DirEncode) begin
      if (pos == 2'd3) pos = 2'd0;
      case (pos)
        2'd0:    buf_e = grp_i.buffer | {byte_i, 16'h0000};
        2'd1:    buf_e = grp_i.buffer | {8'h00, byte_i, 8'h00};
        default: buf_e = grp_i.buffer | {16'h0000, byte_i};
      endcase
      pos1 = {1'b0, pos} + 3'd1;
      if (pos1 == 3'd3 || last_i) begin
        emit = (pos1 == 3'd3) ? 3'd4 : pos1 + 3'd1;
        for (int i = 0; i < 4; i++) begin
          burst_o.bytes[i] = (3'(i) < emit) ? enc_char(buf_e[23 - 6*i -: 6]) : PadChar;
        end
        burst_o.count = 3'd4;
        grp_o.buffer  = '0;
        grp_o.pos     = 2'd0;
      end else begin
        grp_o.buffer = buf_e;
        grp_o.pos    = pos1[1:0];
      end
    end else if (!grp_i.pad_seen) begin
      if (byte_i == PadChar) begin
        if (pos >= 2'd2) burst_o.count = {1'b0, pos} - 3'd1;
        burst_o.bad     = grp_i.bad;
        grp_o.pos       = 2'd0;
        grp_o.buffer    = '0;
        grp_o.bad       = 1'b0;
        grp_o.pad_seen  = 1'b1;
      end else if (pos != 2'd3) begin
        case (pos)
          2'd0:    buf_d = grp_i.buffer | {v[5:0], 18'h0};
          2'd1:    buf_d = grp_i.buffer | {6'h0, v[5:0], 12'h0};
          default: buf_d = grp_i.buffer | {12'h0, v[5:0], 6'h0};
        endcase
        dbuf          = buf_d;
        pos1          = {1'b0, pos} + 3'd1;
        grp_o.buffer  = buf_d;
        grp_o.pos     = pos1[1:0];
        grp_o.bad     = grp_i.bad | vbad;
        burst_o.bad   = grp_i.bad | vbad;
        if (last_i && pos1 >= 3'd2) burst_o.count = pos1 - 3'd1;
      end else begin
        // fourth character: full 8-bit value joins the last byte mod 256
        d3            = v;
        burst_o.count = 3'd3;
        burst_o.bad   = grp_i.bad | vbad;
        grp_o.pos     = 2'd0;
        grp_o.buffer  = '0;
        grp_o.bad     = 1'b0;
      end
      s0 = dbuf[23:18];
      s1 = dbuf[17:12];
      s2 = dbuf[11:6];
      burst_o.bytes[0] = {s0, s1[5:4]};
      burst_o.bytes[1] = {s1[3:0], s2[5:2]};
      burst_o.bytes[2] = {s2[1:0], 6'h00} + d3;
    end

    if (dir_i == DirEncode || grp_i.pad_seen) begin
      s0 = 6'd0;
      s1 = 6'd0;
      s2 = 6'd0;
    end
    if (last_i) grp_o = '0;
  end

endmodule

FILE: hdl/base64_stream_codec.sv
// Top level of the base64 stream codec: direction register, group state,
// result burst register and handshakes. Depends on b64c_pkg and b64c_step.
//
// Base64 (standard alphabet, '=' padding) codec over a byte stream. Each
// accepted item is processed in the cycle it is taken; its results (up to
// four) are loaded into a burst register and leave one per cycle while
// out_stall_i is low. An item that causes no result does not stall the
// input; an item that causes results holds the input side until its burst
// drains, the next item being taken in the cycle the last result is taken.
// Write direction only while the codec is idle; a write clears group state.
module base64_stream_codec (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_direction_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       out_run_end_o,
  output logic       out_message_end_o,
  output logic       out_bad_char_o
);
  import b64c_pkg::*;

  logic            dir_q;
  group_t          grp_q, grp_d, grp_step;
  burst_t          step_burst;
  logic [3:0][7:0] bytes_q;
  logic [2:0]      left_q, left_d;
  logic [1:0]      idx_q, idx_d;
  logic            bad_q;
  logic            last_q;
  logic            in_fire, out_fire, cfg_fire, load;

  b64c_step u_step (
    .dir_i   (dir_q),
    .grp_i   (grp_q),
    .byte_i  (in_byte_i),
    .last_i  (in_last_i),
    .grp_o   (grp_step),
    .burst_o (step_burst)
  );

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i & cfg_ready_o;

  assign out_valid_o       = (left_q != 3'd0);
  assign out_byte_o        = bytes_q[idx_q];
  assign out_run_end_o     = (left_q == 3'd1);
  assign out_message_end_o = (left_q == 3'd1) & last_q;
  assign out_bad_char_o    = bad_q;
  assign out_fire          = out_valid_o & ~out_stall_i;

  // free when empty, or when the final result of the burst goes this cycle
  assign in_stall_o = (left_q != 3'd0) & ~((left_q == 3'd1) & ~out_stall_i);
  assign in_fire    = in_valid_i & ~in_stall_o;
  assign load       = in_fire & (step_burst.count != 3'd0);

  always_comb begin
    grp_d  = grp_q;
    left_d = left_q;
    idx_d  = idx_q;
    if (cfg_fire) grp_d = '0;
    else if (in_fire) grp_d = grp_step;
    if (load) begin
      left_d = step_burst.count;
      idx_d  = 2'd0;
    end else if (out_fire) begin
      left_d = left_q - 3'd1;
      idx_d  = idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q  <= DirEncode;
      grp_q  <= '0;
      left_q <= 3'd0;
      idx_q  <= 2'd0;
    end else begin
      if (cfg_fire) dir_q <= cfg_direction_i;
      grp_q  <= grp_d;
      left_q <= left_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      bytes_q <= step_burst.bytes;
      bad_q   <= step_burst.bad;
      last_q  <= in_last_i;
    end
  end

endmodule
